// File: rtl/xt_pkg.sv
`timescale 1ns / 1ps

package xt_pkg;

    // Default round count and the XTEA round constant
    localparam int    XT_ROUNDS = 32;
    localparam int    XT_WORD_W = 32;
    localparam logic [XT_WORD_W-1:0] XT_DELTA = 32'h9E37_79B9;

    typedef logic [XT_WORD_W-1:0] t_word;

    // Four key words, index 0 in the low slot
    typedef t_word [3:0] t_key;

    // One 64-bit block in flight
    typedef struct packed {
        t_word v0;
        t_word v1;
    } t_blk;

    // Register map, one key word per 32-bit slot
    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    // Running sum after n additions of the round constant, mod 2^32
    function automatic t_word round_sum(input int unsigned n);
        logic [63:0] p;
        p = 64'(n) * 64'(XT_DELTA);
        return p[XT_WORD_W-1:0];
    endfunction

endpackage

// File: rtl/xt_cell.sv
`timescale 1ns / 1ps

// One half-round of XTEA: even cells update v0, odd cells update v1.
// The running sum and the key slot are fixed per cell.
module xt_cell
    import xt_pkg::*;
#(
    parameter int HALF = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_blk i_blk,
    input  t_key i_key,
    output logic o_valid,
    output t_blk o_blk
);

    localparam bit    SECOND  = (HALF % 2) == 1;
    localparam t_word SUM     = round_sum(HALF / 2 + HALF % 2);
    localparam logic [1:0] KEY_SEL = SECOND ? SUM[12:11] : SUM[1:0];

    logic  r_valid;
    t_blk  r_blk;
    t_blk  n_blk;
    t_word src;
    t_word mix;
    t_word rkey;

    // Feistel half step
    always_comb begin
        src  = SECOND ? i_blk.v0 : i_blk.v1;
        mix  = ((src << 4) ^ (src >> 5)) + src;
        rkey = SUM + i_key[KEY_SEL];
        n_blk = i_blk;
        if (SECOND) begin
            n_blk.v1 = i_blk.v1 + (mix ^ rkey);
        end else begin
            n_blk.v0 = i_blk.v0 + (mix ^ rkey);
        end
    end

    // Stage register, advances with the shared enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

// File: rtl/xt_skid.sv
`timescale 1ns / 1ps

// Output register plus one skid word; ready toward the chain is registered.
module xt_skid
    import xt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_blk i_blk,
    output logic o_ready,
    output logic o_valid,
    output t_blk o_blk,
    input  logic i_ready
);

    logic r_out_valid;
    logic r_skid_valid;
    t_blk r_out;
    t_blk r_skid;
    logic push;
    logic pop;

    assign o_ready = !r_skid_valid;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_out_valid && i_ready;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Data
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_blk;
            end else begin
                r_out <= i_blk;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_blk   = r_out;

endmodule

// File: rtl/xtea_block_encrypt.sv
`timescale 1ns / 1ps

// XTEA encryption of 64-bit blocks under a 128-bit key.
// Input channel: i_in_valid / o_in_ready carry one plaintext word
// (i_plain_first, i_plain_second). Output channel: o_out_valid /
// i_out_ready carry the matching ciphertext word, in order.
// Key: four 32-bit words on the APB port at 0x0, 0x4, 0x8, 0xC; readable.
// Write the key only while no word is in flight.
// Datapath is a chain of 2*ROUNDS half-round cells, one register each,
// followed by an output register and a one-word skid buffer.
// Throughput: one word per cycle while the receiver takes words.
// When the receiver stalls, the skid word absorbs one more result; then
// o_in_ready drops and the whole chain holds until the output is taken.
// Reset (synchronous, active low) empties the chain and the output
// stage and clears the key to zero.
module xtea_block_encrypt
    import xt_pkg::*;
#(
    parameter int ROUNDS = XT_ROUNDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // plaintext channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_plain_first,
    input  logic [31:0] i_plain_second,
    // ciphertext channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_cipher_first,
    output logic [31:0] o_cipher_second,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS = 2 * ROUNDS;

    t_key     r_key;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     en;
    logic     skid_ready;
    t_blk     out_blk;

    logic [CELLS:0] stg_valid;
    t_blk           stg_blk [CELLS+1];

    // Key registers
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_KEY0: r_key[0] <= pwdata;
                REG_KEY1: r_key[1] <= pwdata;
                REG_KEY2: r_key[2] <= pwdata;
                REG_KEY3: r_key[3] <= pwdata;
                default:  r_key[0] <= r_key[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY0: prdata = r_key[0];
            REG_KEY1: prdata = r_key[1];
            REG_KEY2: prdata = r_key[2];
            REG_KEY3: prdata = r_key[3];
            default:  prdata = '0;
        endcase
    end

    // Chain advances whenever the skid word is free
    assign en         = skid_ready;
    assign o_in_ready = en;

    assign stg_valid[0]  = i_in_valid;
    assign stg_blk[0].v0 = i_plain_first;
    assign stg_blk[0].v1 = i_plain_second;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        xt_cell #(
            .HALF (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[g]),
            .i_blk   (stg_blk[g]),
            .i_key   (r_key),
            .o_valid (stg_valid[g+1]),
            .o_blk   (stg_blk[g+1])
        );
    end

    // Output register and skid
    xt_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[CELLS]),
        .i_blk   (stg_blk[CELLS]),
        .o_ready (skid_ready),
        .o_valid (o_out_valid),
        .o_blk   (out_blk),
        .i_ready (i_out_ready)
    );

    assign o_cipher_first  = out_blk.v0;
    assign o_cipher_second = out_blk.v1;

endmodule

// File: rtl/xt_checker.sv
`timescale 1ns / 1ps

module xt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_cipher_first,
    input logic [31:0] o_cipher_second,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // Input is only held off while a result is waiting at the output
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_cipher_first) && $stable(o_cipher_second))
        else $error("output word changed under stall");

    // Config port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    // A key word reads back what was just written
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite ##1 (paddr[3:2] == $past(paddr[3:2]))
            |-> prdata == $past(pwdata))
        else $error("key readback mismatch");

endmodule

bind xtea_block_encrypt xt_checker u_xt_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import xt_pkg::*;

    // Expected ciphertext words, worked out from the plaintext words taken in
    class cipher_scoreboard;
        t_word       key_copy [4] = '{default: '0};
        t_blk        pending_cipher [$];
        int unsigned mismatches = 0;

        // Full XTEA encipher of one block under the mirrored key
        function automatic t_blk encipher(input t_word p0, input t_word p1);
            t_word a;
            t_word b;
            t_word s;
            t_blk  c;
            a = p0;
            b = p1;
            s = '0;
            for (int r = 0; r < XT_ROUNDS; r++) begin
                a += (((b << 4) ^ (b >> 5)) + b) ^ (s + key_copy[s[1:0]]);
                s += XT_DELTA;
                b += (((a << 4) ^ (a >> 5)) + a) ^ (s + key_copy[s[12:11]]);
            end
            c.v0 = a;
            c.v1 = b;
            return c;
        endfunction

        function void note_plain(input t_word p0, input t_word p1);
            pending_cipher.push_back(encipher(p0, p1));
        endfunction

        function void check_cipher(input t_word c0, input t_word c1);
            t_blk want;
            if (pending_cipher.size() == 0) begin
                $error("unexpected word: cipher_first=%h cipher_second=%h", c0, c1);
                mismatches++;
                return;
            end
            want = pending_cipher.pop_front();
            if (c0 !== want.v0) begin
                $error("cipher_first: expected %h, got %h", want.v0, c0);
                mismatches++;
            end
            if (c1 !== want.v1) begin
                $error("cipher_second: expected %h, got %h", want.v1, c1);
                mismatches++;
            end
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_WORDS = 220;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_plain_first = '0;
    logic [31:0] i_plain_second = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_cipher_first;
    logic [31:0] o_cipher_second;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cipher_scoreboard board = new;
    bit               steady = 1'b0;
    int unsigned      cycles = 0;

    xtea_block_encrypt u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_plain_first  (i_plain_first),
        .i_plain_second (i_plain_second),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cipher_first (o_cipher_first),
        .o_cipher_second(o_cipher_second),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver back-pressure, off while steady
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_out_ready <= steady || ($urandom_range(0, 99) >= 7);
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_cipher(o_cipher_first, o_cipher_second);
        end
    end

    // Mostly random, with a bias toward all-zero, all-one and one-hot words
    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return t_word'(1) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // APB write: setup cycle, then access cycle
    task automatic write_key(input t_reg_idx idx, input t_word value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.key_copy[idx] = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_key(input t_word k0, input t_word k1,
                            input t_word k2, input t_word k3);
        write_key(REG_KEY0, k0);
        write_key(REG_KEY1, k1);
        write_key(REG_KEY2, k2);
        write_key(REG_KEY3, k3);
    endtask

    // Present one plaintext word, with a random gap ahead of it when not steady
    task automatic send_block(input t_word first, input t_word second);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_plain_first  <= first;
        i_plain_second <= second;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_plain(first, second);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending_cipher.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the all-zero reset key
        send_block('0, '0);
        send_block('1, '1);
        send_block('0, '1);
        send_block('1, '0);
        send_block(32'hAAAA_AAAA, 32'h5555_5555);
        send_block(32'h5555_5555, 32'hAAAA_AAAA);
        send_block(32'h8000_0000, 32'h0000_0001);
        send_block(32'h0000_0001, 32'h8000_0000);
        send_block(32'h0123_4567, 32'h89AB_CDEF);
        for (int i = 0; i < 32; i += 4) begin
            send_block(t_word'(1) << i, t_word'(1) << (31 - i));
        end
        drain();

        // Extreme keys, then random ones
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       load_key('1, '1, '1, '1);
                1:       load_key('0, '1, '0, '1);
                2:       load_key(32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
                default: load_key(pick_word(), pick_word(), pick_word(), pick_word());
            endcase
            steady = (ph == 3);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_block(pick_word(), pick_word());
            end
            drain();
            steady = 1'b0;
        end

        // Let any stray output show up before the verdict
        repeat (2 * XT_ROUNDS + 8) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_cipher.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
